>>> src/pltss_pkg.sv
// shared types and constants for the three-ordinate breakpoint table
package pltss_pkg;

  localparam int DefTableDepth = 64;
  localparam int CmdQueueDepth = 2;
  localparam int ResQueueDepth = 2;
  localparam int DataW         = 32;
  localparam int IndexW        = 6;
  localparam int CountW        = 7;
  localparam int RegionW       = 2;
  localparam int NumOrd        = 3;

  typedef enum logic {
    OP_WRITE  = 1'b0,
    OP_SAMPLE = 1'b1
  } op_e;

  localparam logic [RegionW-1:0] RegionInterp = 2'd0;
  localparam logic [RegionW-1:0] RegionFirst  = 2'd1;
  localparam logic [RegionW-1:0] RegionLast   = 2'd2;

  typedef struct packed {
    op_e                           op;
    logic [IndexW-1:0]             idx;
    logic [DataW-1:0]              x;
    logic [NumOrd-1:0][DataW-1:0]  y;
  } cmd_t;

  typedef struct packed {
    logic [DataW-1:0]              x;
    logic [NumOrd-1:0][DataW-1:0]  y;
  } entry_t;

  typedef struct packed {
    logic [NumOrd-1:0][DataW-1:0]  val;
    logic [RegionW-1:0]            region;
  } res_t;

endpackage

>>> src/pltss_fifo.sv
// small register queue used between the front, the engine and the result ports
module pltss_fifo import pltss_pkg::*; #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] data_i,
  output logic         full_o,
  input  logic         pop_i,
  output logic [W-1:0] data_o,
  output logic         empty_o
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem_q [DEPTH];
  logic [AW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          wr_en, rd_en;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign wr_en   = push_i && !full_o;
  assign rd_en   = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (wr_en) begin
      wr_ptr_d = (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
    end
    if (rd_en) begin
      rd_ptr_d = (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
    end
    if (wr_en && !rd_en) begin
      cnt_d = cnt_q + CW'(1);
    end else if (rd_en && !wr_en) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

>>> src/pltss_div.sv
// radix-2 restoring divider, 64-bit dividend whose quotient fits 32 bits
module pltss_div import pltss_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [2*DataW-1:0] dividend_i,
  input  logic [DataW-1:0]   divisor_i,
  output logic               done_o,
  output logic [DataW-1:0]   quot_o
);

  localparam int StepW = $clog2(DataW + 1);

  logic [DataW-1:0] rem_q, rem_d, lo_q, lo_d, dvs_q;
  logic [StepW-1:0] step_q, step_d;
  logic             busy_q, busy_d, done_q, done_d;
  logic [DataW:0]   trial;
  logic             ge;

  assign trial  = {rem_q, lo_q[DataW-1]};
  assign ge     = trial >= {1'b0, dvs_q};
  assign done_o = done_q;
  assign quot_o = lo_q;

  always_comb begin
    rem_d  = rem_q;
    lo_d   = lo_q;
    step_d = step_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      // high half is already below the divisor, so only 32 steps remain
      rem_d  = dividend_i[2*DataW-1:DataW];
      lo_d   = dividend_i[DataW-1:0];
      step_d = StepW'(DataW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d  = ge ? DataW'(trial - {1'b0, dvs_q}) : trial[DataW-1:0];
      lo_d   = {lo_q[DataW-2:0], ge};
      step_d = step_q - StepW'(1);
      if (step_q == StepW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    lo_q  <= lo_d;
    if (start_i) begin
      dvs_q <= divisor_i;
    end
  end

endmodule

>>> src/pltss_engine.sv
// back end: table memory, interval scan and interpolation sequencer
module pltss_engine import pltss_pkg::*; #(
  parameter int TABLE_DEPTH = DefTableDepth
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [CountW-1:0] count_i,
  input  cmd_t              cmd_i,
  input  logic              cmd_empty_i,
  output logic              cmd_pop_o,
  output res_t              res_o,
  output logic              res_push_o,
  input  logic              res_full_i
);

  localparam int AW = $clog2(TABLE_DEPTH);

  typedef enum logic [2:0] {
    S_IDLE, S_RD0, S_SCAN, S_MUL, S_DSTART, S_DIV, S_OUT
  } state_e;

  state_e                       state_q;
  entry_t                       mem_q [TABLE_DEPTH];
  entry_t                       rdata_q, lo_q, hi_q;
  logic   [AW-1:0]              raddr, idx_q, last_q;
  logic   [DataW-1:0]           x_q, span_q, dx_q, p_q;
  logic   [2*DataW-1:0]         prod_q;
  logic                         neg_q;
  logic   [1:0]                 k_q;
  logic   [NumOrd-1:0][DataW-1:0] val_q;
  logic   [RegionW-1:0]         region_q;
  logic   [31:0]                widx, cnt_ext, neff;
  logic                         wr_ok, in_iv;
  logic   [DataW:0]             d_span, d_dx, diff, ndiff;
  logic   [DataW-1:0]           p_sel, q_sel, mag;
  logic                         div_start, div_done;
  logic   [DataW-1:0]           quot;

  assign widx    = 32'(cmd_i.idx);
  assign wr_ok   = widx < 32'(TABLE_DEPTH);
  assign cnt_ext = 32'(count_i);

  always_comb begin
    neff = (cnt_ext == 32'd0) ? 32'd1 : cnt_ext;
    if (neff > 32'(TABLE_DEPTH)) begin
      neff = 32'(TABLE_DEPTH);
    end
  end

  // t1 <= x < t2 with t1 from the held entry and t2 from the fresh read
  assign in_iv  = ($signed(lo_q.x) <= $signed(x_q)) && ($signed(x_q) < $signed(rdata_q.x));
  assign d_span = {rdata_q.x[DataW-1], rdata_q.x} - {lo_q.x[DataW-1], lo_q.x};
  assign d_dx   = {x_q[DataW-1], x_q} - {lo_q.x[DataW-1], lo_q.x};

  assign p_sel = lo_q.y[k_q];
  assign q_sel = hi_q.y[k_q];
  assign diff  = {q_sel[DataW-1], q_sel} - {p_sel[DataW-1], p_sel};
  assign ndiff = -diff;
  assign mag   = diff[DataW] ? ndiff[DataW-1:0] : diff[DataW-1:0];

  assign cmd_pop_o  = (state_q == S_IDLE) && !cmd_empty_i;
  assign div_start  = (state_q == S_DSTART);
  assign res_push_o = (state_q == S_OUT) && !res_full_i;
  assign res_o      = '{val: val_q, region: region_q};

  always_comb begin
    raddr = '0;
    case (state_q)
      S_RD0:   raddr = AW'(1);
      S_SCAN:  raddr = idx_q + AW'(1);
      default: raddr = '0;
    endcase
  end

  pltss_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (prod_q),
    .divisor_i  (span_q),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr];
    if (cmd_pop_o && (cmd_i.op == OP_WRITE) && wr_ok) begin
      mem_q[widx[AW-1:0]] <= '{x: cmd_i.x, y: cmd_i.y};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      k_q     <= '0;
      idx_q   <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (cmd_pop_o && (cmd_i.op == OP_SAMPLE)) begin
            x_q     <= cmd_i.x;
            last_q  <= AW'(neff - 32'd1);
            state_q <= S_RD0;
          end
        end
        S_RD0: begin
          if ($signed(x_q) <= $signed(rdata_q.x)) begin
            val_q    <= rdata_q.y;
            region_q <= RegionFirst;
            state_q  <= S_OUT;
          end else if (last_q == '0) begin
            val_q    <= rdata_q.y;
            region_q <= RegionLast;
            state_q  <= S_OUT;
          end else begin
            lo_q    <= rdata_q;
            idx_q   <= AW'(1);
            state_q <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (in_iv) begin
            hi_q     <= rdata_q;
            span_q   <= d_span[DataW-1:0];
            dx_q     <= d_dx[DataW-1:0];
            k_q      <= '0;
            region_q <= RegionInterp;
            state_q  <= S_MUL;
          end else if (idx_q == last_q) begin
            val_q    <= rdata_q.y;
            region_q <= RegionLast;
            state_q  <= S_OUT;
          end else begin
            lo_q    <= rdata_q;
            idx_q   <= idx_q + AW'(1);
          end
        end
        S_MUL: begin
          prod_q  <= mag * dx_q;
          neg_q   <= diff[DataW];
          p_q     <= p_sel;
          state_q <= S_DSTART;
        end
        S_DSTART: begin
          state_q <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            val_q[k_q] <= neg_q ? p_q - quot : p_q + quot;
            if (k_q == 2'd2) begin
              state_q <= S_OUT;
            end else begin
              k_q     <= k_q + 2'd1;
              state_q <= S_MUL;
            end
          end
        end
        S_OUT: begin
          if (!res_full_i) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

>>> src/piecewise_linear_table_sample_three.sv
// piecewise-linear breakpoint table with three ordinates per entry
//
// Input side is a queue: present command, entry_index, abscissa and
// ordinates with push; the beat is taken when push is high and full is low.
// A write command stores one entry and gives no result. A sample command
// gives one result beat: the three ordinates at the abscissa plus region
// (interpolated, clamped to the first entry, clamped to the last entry).
// Result side is a queue: a beat is shown while empty is low and leaves
// when pop is high. The configuration channel writes entry_count on
// cfg_valid_i, cfg_ready_o is always high; write it only while idle.
// A sample reads entry 0 and clamps to it when the abscissa is at or below
// it; else it scans entries in order, one per cycle, until it clamps to the
// last of n or finds the interval, then multiplies and divides for each of
// the three ordinates in turn. A write leaves the engine idle.
// A two-deep command queue and a two-deep result queue
// decouple both sides; a stalled receiver fills the result queue, then the
// engine waits and the command queue fills, raising full.
// Reset clears the queues and sets entry_count to 1; the table contents
// stay undefined until written.
module piecewise_linear_table_sample_three import pltss_pkg::*; #(
  parameter int TABLE_DEPTH = DefTableDepth
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CountW-1:0]   cfg_data_i,
  input  logic                push,
  output logic                full,
  input  logic                command_i,
  input  logic [IndexW-1:0]   entry_index_i,
  input  logic signed [DataW-1:0] abscissa_i,
  input  logic signed [DataW-1:0] ordinate_a_i,
  input  logic signed [DataW-1:0] ordinate_b_i,
  input  logic signed [DataW-1:0] ordinate_c_i,
  output logic                empty,
  input  logic                pop,
  output logic signed [DataW-1:0] value_a_o,
  output logic signed [DataW-1:0] value_b_o,
  output logic signed [DataW-1:0] value_c_o,
  output logic [RegionW-1:0]  region_o
);

  logic [CountW-1:0] count_q;
  cmd_t              cmd_in, cmd_head;
  logic              cmd_empty, cmd_pop;
  res_t              res_in, res_head;
  logic              res_push, res_full;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= CountW'(1);
    end else if (cfg_valid_i && cfg_ready_o) begin
      count_q <= cfg_data_i;
    end
  end

  // classify the beat on entry
  assign cmd_in = '{
    op:  command_i ? OP_SAMPLE : OP_WRITE,
    idx: entry_index_i,
    x:   abscissa_i,
    y:   {ordinate_c_i, ordinate_b_i, ordinate_a_i}
  };

  pltss_fifo #(.W($bits(cmd_t)), .DEPTH(CmdQueueDepth)) u_cmd_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (cmd_in),
    .full_o  (full),
    .pop_i   (cmd_pop),
    .data_o  (cmd_head),
    .empty_o (cmd_empty)
  );

  pltss_engine #(.TABLE_DEPTH(TABLE_DEPTH)) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .count_i     (count_q),
    .cmd_i       (cmd_head),
    .cmd_empty_i (cmd_empty),
    .cmd_pop_o   (cmd_pop),
    .res_o       (res_in),
    .res_push_o  (res_push),
    .res_full_i  (res_full)
  );

  pltss_fifo #(.W($bits(res_t)), .DEPTH(ResQueueDepth)) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_in),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (res_head),
    .empty_o (empty)
  );

  assign value_a_o = res_head.val[0];
  assign value_b_o = res_head.val[1];
  assign value_c_o = res_head.val[2];
  assign region_o  = res_head.region;

endmodule
